@@ sv/mau_pkg.sv @@
// package for the multiply/accumulate unit
// holds instruction field positions, register codes and the control struct
// no dependencies
package mau_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned DWORD_W = 64;
	localparam int unsigned IDX_W = 4;

	// register index of the program counter
	localparam logic [IDX_W-1:0] PC_INDEX = 4'hF;

	// op codes
	localparam logic OP_SHORT = 1'b0;
	localparam logic OP_LONG = 1'b1;

	// instruction bit positions
	localparam int unsigned SIGN_BIT = 22;
	localparam int unsigned ACC_BIT = 21;
	localparam int unsigned SETF_BIT = 20;
	localparam int unsigned HI_LSB = 16;
	localparam int unsigned LO_LSB = 12;
	localparam int unsigned RS_LSB = 8;
	localparam int unsigned RM_LSB = 0;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [DWORD_W-1:0] dword_t;
	typedef logic [IDX_W-1:0] idx_t;

	// decoded control carried down the pipeline
	typedef struct packed {
		logic skipped;
		logic is_long;
		logic sgn;
		logic acc;
		logic setf;
		idx_t dest_index;
		idx_t second_index;
	} ctrl_t;

endpackage

@@ sv/mau_decode.sv @@
// instruction decoder for the multiply/accumulate unit
// extracts flags and register indexes and rejects unpredictable register use
// depends on mau_pkg
module mau_decode (
	input  logic              op,
	input  mau_pkg::word_t    instruction,
	output mau_pkg::ctrl_t    ctrl
);

	mau_pkg::idx_t f_hi;
	mau_pkg::idx_t f_lo;
	mau_pkg::idx_t f_s;
	mau_pkg::idx_t f_m;
	logic          uses_pc;
	logic          is_long;

	// register index fields
	assign f_hi = instruction[mau_pkg::HI_LSB +: mau_pkg::IDX_W];
	assign f_lo = instruction[mau_pkg::LO_LSB +: mau_pkg::IDX_W];
	assign f_s  = instruction[mau_pkg::RS_LSB +: mau_pkg::IDX_W];
	assign f_m  = instruction[mau_pkg::RM_LSB +: mau_pkg::IDX_W];
	assign is_long = (op == mau_pkg::OP_LONG);

	assign uses_pc = (f_hi == mau_pkg::PC_INDEX) || (f_lo == mau_pkg::PC_INDEX) ||
		(f_s == mau_pkg::PC_INDEX) || (f_m == mau_pkg::PC_INDEX);

	// reject checks and field selection
	always_comb begin
		ctrl.is_long      = is_long;
		ctrl.sgn          = instruction[mau_pkg::SIGN_BIT];
		ctrl.acc          = instruction[mau_pkg::ACC_BIT];
		ctrl.setf         = instruction[mau_pkg::SETF_BIT];
		ctrl.second_index = f_hi;
		if (is_long) begin
			ctrl.skipped    = uses_pc || (f_m == f_hi) || (f_m == f_lo) || (f_hi == f_lo);
			ctrl.dest_index = f_lo;
		end else begin
			ctrl.skipped    = uses_pc || (f_hi == f_m);
			ctrl.dest_index = f_hi;
		end
	end

endmodule

@@ sv/mau_mult.sv @@
// multiply stage of the multiply/accumulate unit
// forms the 64-bit product and the addend, registered into stage 2
// depends on mau_pkg
module mau_mult (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  mau_pkg::ctrl_t   ctrl_s1,
	input  mau_pkg::word_t   rm_s1,
	input  mau_pkg::word_t   rs_s1,
	input  mau_pkg::word_t   acc_low_s1,
	input  mau_pkg::word_t   acc_high_s1,
	output logic             valid_s2,
	output mau_pkg::ctrl_t   ctrl_s2,
	output mau_pkg::dword_t  prod_s2,
	output mau_pkg::dword_t  addend_s2
);

	logic                            ext_sign;
	logic signed [mau_pkg::WORD_W:0] op_a;
	logic signed [mau_pkg::WORD_W:0] op_b;
	logic signed [2*mau_pkg::WORD_W+1:0] prod_full;
	mau_pkg::dword_t                 addend;

	// operands widened by one bit, sign extended for signed long forms
	assign ext_sign = ctrl_s1.is_long && ctrl_s1.sgn;
	assign op_a = {ext_sign & rm_s1[mau_pkg::WORD_W-1], rm_s1};
	assign op_b = {ext_sign & rs_s1[mau_pkg::WORD_W-1], rs_s1};
	assign prod_full = op_a * op_b;

	// accumulate operand selection
	always_comb begin
		if (!ctrl_s1.acc) begin
			addend = '0;
		end else if (ctrl_s1.is_long) begin
			addend = {acc_high_s1, acc_low_s1};
		end else begin
			addend = {{mau_pkg::WORD_W{1'b0}}, acc_low_s1};
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		ctrl_s2   <= ctrl_s1;
		prod_s2   <= prod_full[mau_pkg::DWORD_W-1:0];
		addend_s2 <= addend;
	end

endmodule

@@ sv/mau_accum.sv @@
// accumulate and result stage of the multiply/accumulate unit
// adds the addend, forms flags and drives the result register
// depends on mau_pkg
module mau_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	input  mau_pkg::ctrl_t   ctrl_s2,
	input  mau_pkg::dword_t  prod_s2,
	input  mau_pkg::dword_t  addend_s2,
	output logic             done,
	output logic             skipped,
	output mau_pkg::idx_t    dest_index,
	output mau_pkg::word_t   dest_value,
	output logic             write_second,
	output mau_pkg::idx_t    second_index,
	output mau_pkg::word_t   second_value,
	output logic             flags_valid,
	output logic             n_flag,
	output logic             z_flag
);

	mau_pkg::dword_t sum;
	mau_pkg::word_t  sum_lo;
	mau_pkg::word_t  sum_hi;
	logic            res_n;
	logic            res_z;

	// 64-bit accumulate with carry into the high word
	assign sum    = prod_s2 + addend_s2;
	assign sum_lo = sum[mau_pkg::WORD_W-1:0];
	assign sum_hi = sum[mau_pkg::DWORD_W-1:mau_pkg::WORD_W];

	// flag values for short and long forms
	always_comb begin
		if (ctrl_s2.is_long) begin
			res_n = sum_hi[mau_pkg::WORD_W-1];
			res_z = (sum == '0);
		end else begin
			res_n = sum_lo[mau_pkg::WORD_W-1];
			res_z = (sum_lo == '0);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	// result register, cleared fields on rejected requests
	always_ff @(posedge clk) begin
		skipped      <= ctrl_s2.skipped;
		dest_index   <= '0;
		dest_value   <= '0;
		write_second <= 1'b0;
		second_index <= '0;
		second_value <= '0;
		flags_valid  <= 1'b0;
		n_flag       <= 1'b0;
		z_flag       <= 1'b0;
		if (!ctrl_s2.skipped) begin
			dest_index <= ctrl_s2.dest_index;
			dest_value <= sum_lo;
			if (ctrl_s2.is_long) begin
				write_second <= 1'b1;
				second_index <= ctrl_s2.second_index;
				second_value <= sum_hi;
			end
			if (ctrl_s2.setf) begin
				flags_valid <= 1'b1;
				n_flag      <= res_n;
				z_flag      <= res_z;
			end
		end
	end

endmodule

@@ sv/multiply_accumulate_unit_top.sv @@
// multiply/accumulate unit, top level: MUL/MLA and UMULL/UMLAL/SMULL/SMLAL
// result path: a request accepted at one edge shows its result with done high
// once it has passed the input, product and result registers
// throughput: one request per cycle; busy is always low, the 32x32 multiplier
// is fully pipelined; results are not held, the receiver cannot stall
// reset: arst_n clears the valid bits and done; data registers are not reset
module multiply_accumulate_unit_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             op,
	input  mau_pkg::word_t   instruction,
	input  mau_pkg::word_t   rm_value,
	input  mau_pkg::word_t   rs_value,
	input  mau_pkg::word_t   acc_low,
	input  mau_pkg::word_t   acc_high,
	output logic             done,
	output logic             skipped,
	output mau_pkg::idx_t    dest_index,
	output mau_pkg::word_t   dest_value,
	output logic             write_second,
	output mau_pkg::idx_t    second_index,
	output mau_pkg::word_t   second_value,
	output logic             flags_valid,
	output logic             n_flag,
	output logic             z_flag
);

	logic            valid_s1;
	logic            op_s1;
	mau_pkg::word_t  instr_s1;
	mau_pkg::word_t  rm_s1;
	mau_pkg::word_t  rs_s1;
	mau_pkg::word_t  acc_low_s1;
	mau_pkg::word_t  acc_high_s1;
	mau_pkg::ctrl_t  ctrl_s1;
	logic            valid_s2;
	mau_pkg::ctrl_t  ctrl_s2;
	mau_pkg::dword_t prod_s2;
	mau_pkg::dword_t addend_s2;

	// pipeline never holds off a request
	assign busy = 1'b0;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		op_s1       <= op;
		instr_s1    <= instruction;
		rm_s1       <= rm_value;
		rs_s1       <= rs_value;
		acc_low_s1  <= acc_low;
		acc_high_s1 <= acc_high;
	end

	// decode
	mau_decode u_decode (
		.op          (op_s1),
		.instruction (instr_s1),
		.ctrl        (ctrl_s1)
	);

	// multiply
	mau_mult u_mult (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.ctrl_s1     (ctrl_s1),
		.rm_s1       (rm_s1),
		.rs_s1       (rs_s1),
		.acc_low_s1  (acc_low_s1),
		.acc_high_s1 (acc_high_s1),
		.valid_s2    (valid_s2),
		.ctrl_s2     (ctrl_s2),
		.prod_s2     (prod_s2),
		.addend_s2   (addend_s2)
	);

	// accumulate and result register
	mau_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.ctrl_s2      (ctrl_s2),
		.prod_s2      (prod_s2),
		.addend_s2    (addend_s2),
		.done         (done),
		.skipped      (skipped),
		.dest_index   (dest_index),
		.dest_value   (dest_value),
		.write_second (write_second),
		.second_index (second_index),
		.second_value (second_value),
		.flags_valid  (flags_valid),
		.n_flag       (n_flag),
		.z_flag       (z_flag)
	);

endmodule
